### hdl/clipped_rectangle_fill_unit_macros.svh
// Assertion macros used by the clipped rectangle fill unit controller
`ifndef CLIPPED_RECTANGLE_FILL_UNIT_MACROS_SVH
`define CLIPPED_RECTANGLE_FILL_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset
`define CRF_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset
`define CRF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/crf_pkg.sv
// Types and constants of the clipped rectangle fill unit
package crf_pkg;

  localparam int RES_REG_W  = 13;
  localparam int PIXB_W     = 3;
  localparam int COORD_W    = 16;
  localparam int POS_W      = 17;
  localparam int COLOR_W    = 32;
  localparam int OFFSET_W   = 26;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [RES_REG_W-1:0] HRES_RESET = 13'd1024;
  localparam logic [RES_REG_W-1:0] VRES_RESET = 13'd768;
  localparam logic [PIXB_W-1:0]    PIXB_RESET = 3'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HRES = 2'd0,
    REG_VRES = 2'd1,
    REG_PIXB = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_STEP = 1'b1
  } in_cmd_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_PUSH
  } state_e;

  typedef struct packed {
    logic [RES_REG_W-1:0] hres;
    logic [RES_REG_W-1:0] vres;
    logic [PIXB_W-1:0]    pixb;
  } cfg_t;

  typedef struct packed {
    logic               cmd;
    logic [COORD_W-1:0] origin_x;
    logic [COORD_W-1:0] origin_y;
    logic [COORD_W-1:0] rect_width;
    logic [COORD_W-1:0] rect_height;
    logic [COLOR_W-1:0] fill_value;
  } in_beat_t;

  typedef struct packed {
    logic                write_valid;
    logic [OFFSET_W-1:0] byte_offset;
    logic [COLOR_W-1:0]  pixel_data;
    logic [PIXB_W-1:0]   byte_count;
    logic                last;
  } out_beat_t;

  typedef struct packed {
    logic load;
    logic step;
    logic idle_step;
    logic calc;
    logic push;
  } dp_cmd_t;

  typedef struct packed {
    logic walking;
  } dp_status_t;

endpackage

### hdl/crf_ifs.sv
// Handshake channel interfaces: input beats, result beats, configuration writes
interface crf_in_if;
  import crf_pkg::*;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [COORD_W-1:0] origin_x;
  logic [COORD_W-1:0] origin_y;
  logic [COORD_W-1:0] rect_width;
  logic [COORD_W-1:0] rect_height;
  logic [COLOR_W-1:0] fill_value;
  modport source (output valid, cmd, origin_x, origin_y, rect_width, rect_height, fill_value,
                  input ready);
  modport sink (input valid, cmd, origin_x, origin_y, rect_width, rect_height, fill_value,
                output ready);
endinterface

interface crf_out_if;
  import crf_pkg::*;
  logic                valid;
  logic                ready;
  logic                write_valid;
  logic [OFFSET_W-1:0] byte_offset;
  logic [COLOR_W-1:0]  pixel_data;
  logic [PIXB_W-1:0]   byte_count;
  logic                last;
  modport source (output valid, write_valid, byte_offset, pixel_data, byte_count, last,
                  input ready);
  modport sink (input valid, write_valid, byte_offset, pixel_data, byte_count, last,
                output ready);
endinterface

interface crf_cfg_if;
  import crf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hdl/crf_cfg_regs.sv
// Configuration register file: resolution and bytes per pixel
module crf_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           wr_valid_i,
  input  logic [crf_pkg::CFG_IDX_W-1:0]  wr_index_i,
  input  logic [crf_pkg::CFG_DATA_W-1:0] wr_data_i,
  output logic                           wr_ready_o,
  output crf_pkg::cfg_t                  cfg_o
);
  import crf_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign wr_ready_o = 1'b1;
  assign cfg_o      = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_valid_i) begin
      case (cfg_reg_e'(wr_index_i))
        REG_HRES: cfg_d.hres = wr_data_i[RES_REG_W-1:0];
        REG_VRES: cfg_d.vres = wr_data_i[RES_REG_W-1:0];
        REG_PIXB: cfg_d.pixb = wr_data_i[PIXB_W-1:0];
        default:  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hres <= HRES_RESET;
      cfg_q.vres <= VRES_RESET;
      cfg_q.pixb <= PIXB_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### hdl/crf_ctrl.sv
// Controller: sequences load, step, offset calculation and result push
`include "clipped_rectangle_fill_unit_macros.svh"

module crf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_cmd_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  crf_pkg::dp_status_t status_i,
  output crf_pkg::dp_cmd_t    cmd_o
);
  import crf_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_cmd_i == CMD_LOAD) begin
            cmd_o.load = 1'b1;
            state_d    = S_PUSH;
          end else if (status_i.walking) begin
            cmd_o.step = 1'b1;
            state_d    = S_MUL;
          end else begin
            cmd_o.idle_step = 1'b1;
            state_d         = S_PUSH;
          end
        end
      end
      S_MUL: begin
        cmd_o.calc = 1'b1;
        state_d    = S_PUSH;
      end
      S_PUSH: begin
        if (out_free) begin
          cmd_o.push = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.push) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `CRF_ASSERT_NEXT(a_step_to_mul, in_valid_i && in_ready_o && in_cmd_i == CMD_STEP && status_i.walking, state_q == S_MUL, "walking step did not enter offset stage")
  `CRF_ASSERT_NEXT(a_push_fills, cmd_o.push, out_valid_q, "pushed result not presented")
  `CRF_ASSERT_IMPL(a_no_overwrite, out_valid_q && !out_ready_i, !cmd_o.push, "result overwritten while stalled")
  `CRF_ASSERT_NEXT(a_one_beat, in_valid_i && in_ready_o, !in_ready_o, "input taken in back-to-back cycles")

endmodule

### hdl/crf_datapath.sv
// Datapath: rectangle walk state, clipping, offset multiply and result registers
module crf_datapath #(
  parameter int MAX_RESOLUTION = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  crf_pkg::cfg_t      cfg_i,
  input  crf_pkg::in_beat_t  in_beat_i,
  input  crf_pkg::dp_cmd_t   cmd_i,
  output crf_pkg::dp_status_t status_o,
  output crf_pkg::out_beat_t out_beat_o
);
  import crf_pkg::*;

  localparam int RES_W = $clog2(MAX_RESOLUTION + 1);
  localparam logic [POS_W-1:0] MAX_RES_P = POS_W'(MAX_RESOLUTION);

  typedef struct packed {
    logic                write_valid;
    logic [OFFSET_W-1:0] byte_offset;
    logic [COLOR_W-1:0]  pixel_data;
    logic                last;
  } res_t;

  logic [POS_W-1:0]   col_q, col_d, row_q, row_d;
  logic [COORD_W-1:0] left_q, left_d;
  logic [POS_W-1:0]   right_q, right_d, bottom_q, bottom_d;
  logic [COLOR_W-1:0] color_q, color_d;
  logic               walking_q, walking_d;

  logic [OFFSET_W-1:0] prod_q;
  logic [POS_W-1:0]    mcol_q;
  logic                vis_q, mlast_q;
  res_t                res_q;
  out_beat_t           out_q;

  logic [POS_W-1:0]  hres_w, vres_w, hres_p, vres_p;
  logic [RES_W-1:0]  hres;
  logic [PIXB_W-1:0] nbytes;
  logic [POS_W-1:0]  ncol, nrow;
  logic              wrap, fin, vis;
  logic [OFFSET_W-1:0] offset;

  assign hres_w = {{(POS_W-RES_REG_W){1'b0}}, cfg_i.hres};
  assign vres_w = {{(POS_W-RES_REG_W){1'b0}}, cfg_i.vres};
  assign hres_p = (hres_w > MAX_RES_P) ? MAX_RES_P : hres_w;
  assign vres_p = (vres_w > MAX_RES_P) ? MAX_RES_P : vres_w;
  assign hres   = hres_p[RES_W-1:0];

  always_comb begin
    if (cfg_i.pixb == '0) begin
      nbytes = 3'd1;
    end else if (cfg_i.pixb inside {[3'd5:3'd7]}) begin
      nbytes = 3'd4;
    end else begin
      nbytes = cfg_i.pixb;
    end
  end

  assign ncol   = col_q + 17'd1;
  assign nrow   = row_q + 17'd1;
  assign wrap   = ncol >= right_q;
  assign fin    = wrap && (nrow >= bottom_q);
  assign vis    = (col_q < hres_p) && (row_q < vres_p);
  assign offset = (prod_q + {{(OFFSET_W-POS_W){1'b0}}, mcol_q})
                  * {{(OFFSET_W-PIXB_W){1'b0}}, nbytes};

  always_comb begin
    col_d     = col_q;
    row_d     = row_q;
    left_d    = left_q;
    right_d   = right_q;
    bottom_d  = bottom_q;
    color_d   = color_q;
    walking_d = walking_q;
    if (cmd_i.load) begin
      left_d    = in_beat_i.origin_x;
      col_d     = {1'b0, in_beat_i.origin_x};
      row_d     = {1'b0, in_beat_i.origin_y};
      right_d   = {1'b0, in_beat_i.origin_x} + {1'b0, in_beat_i.rect_width};
      bottom_d  = {1'b0, in_beat_i.origin_y} + {1'b0, in_beat_i.rect_height};
      color_d   = in_beat_i.fill_value;
      walking_d = (in_beat_i.rect_width != '0) && (in_beat_i.rect_height != '0);
    end else if (cmd_i.step) begin
      if (wrap) begin
        col_d = {1'b0, left_q};
        row_d = nrow;
        if (fin) begin
          walking_d = 1'b0;
        end
      end else begin
        col_d = ncol;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      left_q    <= '0;
      right_q   <= '0;
      bottom_q  <= '0;
      color_q   <= '0;
      walking_q <= 1'b0;
    end else begin
      col_q     <= col_d;
      row_q     <= row_d;
      left_q    <= left_d;
      right_q   <= right_d;
      bottom_q  <= bottom_d;
      color_q   <= color_d;
      walking_q <= walking_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      prod_q  <= {{(OFFSET_W-POS_W){1'b0}}, row_q} * {{(OFFSET_W-RES_W){1'b0}}, hres};
      mcol_q  <= col_q;
      vis_q   <= vis;
      mlast_q <= fin;
    end
    if (cmd_i.load) begin
      res_q.write_valid <= 1'b0;
      res_q.byte_offset <= '0;
      res_q.pixel_data  <= '0;
      res_q.last        <= (in_beat_i.rect_width == '0) || (in_beat_i.rect_height == '0);
    end else if (cmd_i.idle_step) begin
      res_q.write_valid <= 1'b0;
      res_q.byte_offset <= '0;
      res_q.pixel_data  <= '0;
      res_q.last        <= 1'b1;
    end else if (cmd_i.calc) begin
      res_q.write_valid <= vis_q;
      res_q.byte_offset <= vis_q ? offset : '0;
      res_q.pixel_data  <= vis_q ? color_q : '0;
      res_q.last        <= mlast_q;
    end
    if (cmd_i.push) begin
      out_q.write_valid <= res_q.write_valid;
      out_q.byte_offset <= res_q.byte_offset;
      out_q.pixel_data  <= res_q.pixel_data;
      out_q.byte_count  <= nbytes;
      out_q.last        <= res_q.last;
    end
  end

  assign status_o.walking = walking_q;
  assign out_beat_o       = out_q;

endmodule

### hdl/clipped_rectangle_fill_unit.sv
// Clipped rectangle fill unit: top level
//
// Walks a filled rectangle over a linear frame buffer, one pixel per step beat.
// in_i   : valid/ready channel; cmd load latches origin, size and colour,
//          cmd step emits the next pixel in row-major order.
// out_o  : valid/ready channel, exactly one result beat per input beat:
//          write_valid, byte_offset, pixel_data, byte_count, last.
//          Off-screen pixels come out with write_valid clear.
// cfg_i  : register write channel (0 horizontal, 1 vertical resolution,
//          2 bytes per pixel), always ready; write only while idle.
// Flow   : a load or idle step is staged, then pushed to the output register;
//          a walking step passes position/multiply, offset add and scale,
//          then the push into the output register; the controller handles one
//          beat at a time and takes a new beat only after the last push.
// The output register holds a result while the receiver stalls; the next
// input beat is still taken and its result waits in the staging register.
// Reset clears the walk state (idle) and loads the register defaults
// 1024 x 768, one byte per pixel.
module clipped_rectangle_fill_unit #(
  parameter int MAX_RESOLUTION = 4096
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  crf_cfg_if.sink   cfg_i,
  crf_in_if.sink    in_i,
  crf_out_if.source out_o
);
  import crf_pkg::*;

  cfg_t       cfg;
  in_beat_t   in_beat;
  out_beat_t  out_beat;
  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  assign in_beat.cmd         = in_i.cmd;
  assign in_beat.origin_x    = in_i.origin_x;
  assign in_beat.origin_y    = in_i.origin_y;
  assign in_beat.rect_width  = in_i.rect_width;
  assign in_beat.rect_height = in_i.rect_height;
  assign in_beat.fill_value  = in_i.fill_value;

  assign out_o.write_valid = out_beat.write_valid;
  assign out_o.byte_offset = out_beat.byte_offset;
  assign out_o.pixel_data  = out_beat.pixel_data;
  assign out_o.byte_count  = out_beat.byte_count;
  assign out_o.last        = out_beat.last;

  crf_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_i.valid),
    .wr_index_i (cfg_i.index),
    .wr_data_i  (cfg_i.data),
    .wr_ready_o (cfg_i.ready),
    .cfg_o      (cfg)
  );

  crf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_cmd_i    (in_i.cmd),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (dp_status),
    .cmd_o       (dp_cmd)
  );

  crf_datapath #(
    .MAX_RESOLUTION (MAX_RESOLUTION)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_beat_i  (in_beat),
    .cmd_i      (dp_cmd),
    .status_o   (dp_status),
    .out_beat_o (out_beat)
  );

endmodule
